// ===== hw/rtl/sed_pkg.sv =====
// Shared constants, state encoding and control structs for the stereo energy downmix.
package sed_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int MONO_W     = SAMPLE_W + 1;
  localparam int MAX_FRAME  = 256;
  localparam int FRAME_LOG  = $clog2(MAX_FRAME);
  localparam int LR_SQ_W    = 2 * SAMPLE_W - 1;
  localparam int MONO_SQ_W  = 2 * MONO_W - 1;
  localparam int LR_ACC_W   = LR_SQ_W + FRAME_LOG;
  localparam int MONO_ACC_W = MONO_SQ_W + FRAME_LOG;
  localparam int FRAC_W     = 16;
  localparam int Q_W        = 32;
  localparam int DIV_W      = MONO_ACC_W;
  localparam int DIV_CNT_W  = $clog2(Q_W + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_EMIT,
    ST_SNAP,
    ST_BAL_GO,
    ST_BAL_WAIT,
    ST_MIX_GO,
    ST_MIX_WAIT
  } sed_state_t;

  typedef struct packed {
    logic capture;
    logic square;
    logic accum;
    logic snap;
    logic div_start;
    logic div_sel_mix;
    logic store_bal;
    logic store_mix;
    logic load_out;
  } sed_cmd_t;

  typedef struct packed {
    logic last;
    logic div_busy;
    logic div_done;
    logic out_free;
  } sed_status_t;

endpackage

// ===== hw/rtl/sed_div.sv =====
// Restoring Q16.16 divider with saturation, one quotient bit per cycle.
module sed_div
  import sed_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [Q_W-1:0]   quot
);

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dvsr;
  logic [Q_W-1:0]       low;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W:0]       trial;
  logic                 fits;
  logic                 sat;

  // quotient overflows Q_W bits when num >= den << FRAC_W
  assign sat   = {{FRAC_W{1'b0}}, num} >= {den, {FRAC_W{1'b0}}};
  assign trial = {rem, low[Q_W-1]};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      if (sat) begin
        busy <= 1'b0;
        done <= 1'b1;
        quot <= '1;
      end else begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= DIV_CNT_W'(Q_W);
        // divisor held for the whole divide
        dvsr <= den;
        rem  <= num >> FRAC_W;
        low  <= {num[FRAC_W-1:0], {(Q_W-FRAC_W){1'b0}}};
        quot <= '0;
      end
    end else if (busy) begin
      if (fits) begin
        rem  <= DIV_W'(trial - {1'b0, dvsr});
        quot <= {quot[Q_W-2:0], 1'b1};
      end else begin
        rem  <= trial[DIV_W-1:0];
        quot <= {quot[Q_W-2:0], 1'b0};
      end
      low <= {low[Q_W-2:0], 1'b0};
      cnt <= cnt - DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/sed_datapath.sv =====
// Datapath: sample capture, squares, saturating energy sums, ratio divides, output register.
module sed_datapath
  import sed_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  sed_cmd_t                   cmd,
  output sed_status_t                status,
  input  logic signed [SAMPLE_W-1:0] left_sample,
  input  logic signed [SAMPLE_W-1:0] right_sample,
  input  logic                       frame_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [MONO_W-1:0]   mono_sample,
  output logic [Q_W-1:0]             balance_q16,
  output logic [Q_W-1:0]             mix_ratio_q16,
  output logic                       frame_done
);

  logic signed [SAMPLE_W-1:0] left_q;
  logic signed [SAMPLE_W-1:0] right_q;
  logic signed [MONO_W-1:0]   mono_q;
  logic                       last_q;

  logic signed [2*SAMPLE_W-1:0] prod_l;
  logic signed [2*SAMPLE_W-1:0] prod_r;
  logic signed [2*MONO_W-1:0]   prod_m;
  logic [LR_SQ_W-1:0]           sq_left;
  logic [LR_SQ_W-1:0]           sq_right;
  logic [MONO_SQ_W-1:0]         sq_mono;

  logic [LR_ACC_W-1:0]   acc_left;
  logic [LR_ACC_W-1:0]   acc_right;
  logic [MONO_ACC_W-1:0] acc_mono;
  logic [LR_ACC_W:0]     sum_left;
  logic [LR_ACC_W:0]     sum_right;
  logic [MONO_ACC_W:0]   sum_mono;

  logic [DIV_W-1:0] bal_num;
  logic [DIV_W-1:0] bal_den;
  logic [DIV_W-1:0] mix_num;
  logic [DIV_W-1:0] mix_den;
  logic [Q_W-1:0]   bal_q;
  logic [Q_W-1:0]   mix_q;
  logic [Q_W-1:0]   div_quot;
  logic             div_busy;
  logic             div_done;

  assign prod_l = left_q * left_q;
  assign prod_r = right_q * right_q;
  assign prod_m = mono_q * mono_q;

  assign sum_left  = {1'b0, acc_left}  + (LR_ACC_W+1)'(sq_left);
  assign sum_right = {1'b0, acc_right} + (LR_ACC_W+1)'(sq_right);
  assign sum_mono  = {1'b0, acc_mono}  + (MONO_ACC_W+1)'(sq_mono);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      left_q  <= left_sample;
      right_q <= right_sample;
      mono_q  <= MONO_W'(left_sample) + MONO_W'(right_sample);
      last_q  <= frame_end;
    end
    if (cmd.square) begin
      sq_left  <= prod_l[LR_SQ_W-1:0];
      sq_right <= prod_r[LR_SQ_W-1:0];
      sq_mono  <= prod_m[MONO_SQ_W-1:0];
    end
  end

  // energy sums clamp at full scale on overlong frames
  always_ff @(posedge clk) begin
    if (rst || cmd.snap) begin
      acc_left  <= '0;
      acc_right <= '0;
      acc_mono  <= '0;
    end else if (cmd.accum) begin
      acc_left  <= sum_left[LR_ACC_W]    ? '1 : sum_left[LR_ACC_W-1:0];
      acc_right <= sum_right[LR_ACC_W]   ? '1 : sum_right[LR_ACC_W-1:0];
      acc_mono  <= sum_mono[MONO_ACC_W]  ? '1 : sum_mono[MONO_ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      bal_num <= DIV_W'(acc_left) + DIV_W'(1);
      bal_den <= DIV_W'(acc_right) + DIV_W'(1);
      mix_num <= acc_mono;
      mix_den <= DIV_W'(acc_left) + DIV_W'(acc_right) + DIV_W'(1);
    end
    if (cmd.store_bal) begin
      bal_q <= div_quot;
    end
    if (cmd.store_mix) begin
      mix_q <= div_quot;
    end
  end

  sed_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (cmd.div_sel_mix ? mix_num : bal_num),
    .den   (cmd.div_sel_mix ? mix_den : bal_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      mono_sample   <= mono_q;
      frame_done    <= last_q;
      balance_q16   <= last_q ? bal_q : '0;
      mix_ratio_q16 <= last_q ? mix_q : '0;
    end
  end

  assign status.last     = last_q;
  assign status.div_busy = div_busy;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || !out_stall;

endmodule

// ===== hw/rtl/sed_ctrl.sv =====
// Controller state machine sequencing capture, accumulate, divides and output load.
module sed_ctrl
  import sed_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  sed_status_t status,
  output sed_cmd_t    cmd
);

  sed_state_t state;
  sed_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accum = 1'b1;
        if (status.last) begin
          state_next = ST_SNAP;
        end else if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_SNAP: begin
        cmd.snap   = 1'b1;
        state_next = ST_BAL_GO;
      end
      ST_BAL_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_BAL_WAIT;
      end
      ST_BAL_WAIT: begin
        if (status.div_done) begin
          cmd.store_bal = 1'b1;
          state_next    = ST_MIX_GO;
        end
      end
      ST_MIX_GO: begin
        cmd.div_start   = 1'b1;
        cmd.div_sel_mix = 1'b1;
        state_next      = ST_MIX_WAIT;
      end
      ST_MIX_WAIT: begin
        if (status.div_done) begin
          cmd.store_mix = 1'b1;
          state_next    = ST_EMIT;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/stereo_energy_downmix_top.sv =====
// Top level of the stereo energy downmix: controller, datapath and checks.
// Non-final request: accepted, squared, accumulated; result loaded into the output register from
//   the accumulate state, or from the emit state while the output is stalled; next request taken after the load.
// Frame-end request: adds snapshot plus two 32-step divides on one shared divider;
//   a saturating ratio finishes without its divide steps.
// Reset (rst, synchronous): energy sums cleared, output register empty, controller idle.
module stereo_energy_downmix_top
  import sed_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] left_sample,
  input  logic signed [SAMPLE_W-1:0] right_sample,
  input  logic                       frame_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [MONO_W-1:0]   mono_sample,
  output logic [Q_W-1:0]             balance_q16,
  output logic [Q_W-1:0]             mix_ratio_q16,
  output logic                       frame_done
);

  // command and status between the controller and the datapath
  sed_cmd_t    cmd;
  sed_status_t status;

  // The controller takes a request only when idle; a finished result waits
  // in the controller until the output register frees, and no new request
  // is taken meanwhile.
  sed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: 16x16 left/right and 17x17 mono squares registered before the saturating energy adds;
  // on frame end the sums are snapshotted into divider operands and cleared.
  sed_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .left_sample   (left_sample),
    .right_sample  (right_sample),
    .frame_end     (frame_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .mono_sample   (mono_sample),
    .balance_q16   (balance_q16),
    .mix_ratio_q16 (mix_ratio_q16),
    .frame_done    (frame_done)
  );

`ifndef SYNTHESIS
  // divider is never restarted mid-divide
  assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.div_busy)
    else $error("divider started while busy");

  // ratios only appear on a frame-end result
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_done) |-> (balance_q16 == '0 && mix_ratio_q16 == '0))
    else $error("nonzero ratio on non-final result");

  // done is a one-cycle pulse
  assert property (@(posedge clk) disable iff (rst)
    status.div_done |=> !status.div_done)
    else $error("divider done held");

  // a captured request cannot coincide with an output load
  assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> !cmd.load_out)
    else $error("capture and output load overlap");
`endif

endmodule
